// ===== hdl/conv2d_valid_same_engine_defines.svh =====
// Assertion macros used by the checker file of the convolution engine.
`ifndef CONV2D_VALID_SAME_ENGINE_DEFINES_SVH
`define CONV2D_VALID_SAME_ENGINE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CV2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CV2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/cv2d_pkg.sv =====
// Types and constants shared by the convolution engine modules.
`default_nettype none

package cv2d_pkg;

	localparam int MODE_W     = 2;
	localparam int ROW_W      = 6;
	localparam int VALUE_W    = 16;
	localparam int SUM_W      = 36;
	localparam int DIM_W      = 7;
	localparam int KDIM_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int COORD_W    = 9;
	localparam int PROD_W     = 32;

	localparam logic [MODE_W-1:0] MODE_WEIGHT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PIXEL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAD_SAME     = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic [ROW_W-1:0]          row;
		logic [ROW_W-1:0]          col;
		logic signed [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic                    out_of_range;
	} out_item_t;

	typedef struct packed {
		logic store;
		logic start;
		logic tap;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic req_bad;
		logic last_tap;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/cv2d_ram.sv =====
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module cv2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hdl/cv2d_ctrl.sv =====
// Controller state machine that sequences one item at a time.
`default_nettype none

module cv2d_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [cv2d_pkg::MODE_W-1:0]   mode,
	input  wire cv2d_pkg::dp_status_t          st,
	output logic                               in_stall,
	output cv2d_pkg::dp_cmd_t                  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_TAPS   = 3'd1;
	localparam logic [2:0] ST_DRAIN1 = 3'd2;
	localparam logic [2:0] ST_DRAIN2 = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.store  = accept;
		cmd.start  = accept && (mode == cv2d_pkg::MODE_COMPUTE);
		cmd.tap    = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					state_d = st.req_bad ? ST_DONE : ST_TAPS;
				end
			end
			ST_TAPS: begin
				cmd.tap = 1'b1;
				if (st.last_tap) begin
					state_d = ST_DRAIN1;
				end
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_DONE;
			ST_DONE: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cv2d_dp.sv =====
// Datapath: configuration, stores, tap counters, multiply-accumulate and result register.
`default_nettype none

module cv2d_dp #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_KERNEL = 5
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [cv2d_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cv2d_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire cv2d_pkg::in_item_t                in_item,
	input  wire cv2d_pkg::dp_cmd_t                 cmd,
	output cv2d_pkg::dp_status_t                   st,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output cv2d_pkg::out_item_t                    out_item
);

	localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
	localparam int WGT_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
	localparam int ACC_W     = cv2d_pkg::PROD_W + $clog2(WGT_DEPTH + 1);
	localparam int SAT_W     = (ACC_W > cv2d_pkg::SUM_W) ? ACC_W : cv2d_pkg::SUM_W;
	localparam int MAG_W     = cv2d_pkg::COORD_W - 1;
	localparam logic signed [SAT_W-1:0] SUM_TOP =
		{{(SAT_W - cv2d_pkg::SUM_W + 1){1'b0}}, {(cv2d_pkg::SUM_W - 1){1'b1}}};
	localparam logic signed [SAT_W-1:0] SUM_BOT =
		{{(SAT_W - cv2d_pkg::SUM_W + 1){1'b1}}, {(cv2d_pkg::SUM_W - 1){1'b0}}};

	logic [cv2d_pkg::DIM_W-1:0]  width_q, height_q;
	logic [cv2d_pkg::KDIM_W-1:0] ksize_q;
	logic                        pad_q;

	logic [cv2d_pkg::DIM_W-1:0]  w_eff, h_eff;
	logic [cv2d_pkg::KDIM_W-1:0] k_clamp, k_eff, off;
	logic                        req_bad_c;

	logic [cv2d_pkg::ROW_W-1:0]  row_q, col_q;
	logic                        bad_q;
	logic [cv2d_pkg::KDIM_W-1:0] i_q, j_q;

	logic signed [cv2d_pkg::COORD_W-1:0] r_c, c_c;
	logic                                in_image;
	logic [31:0]                         pix_rlin, pix_wlin, wgt_rlin, wgt_wlin;
	logic                                pix_we, wgt_we;
	logic [cv2d_pkg::VALUE_W-1:0]        pix_rdata, wgt_rdata;

	logic                              tap_s1, zero_s1;
	logic                              tap_s2;
	logic signed [cv2d_pkg::PROD_W-1:0] prod_c, prod_s2;
	logic signed [ACC_W-1:0]           acc_q;
	logic signed [SAT_W-1:0]           acc_x;
	logic signed [cv2d_pkg::SUM_W-1:0] sat_sum;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd10;
			height_q <= 7'd10;
			ksize_q  <= 3'd3;
			pad_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cv2d_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				cv2d_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				cv2d_pkg::CFG_KERNEL_SIZE:  ksize_q  <= cfg_data[cv2d_pkg::KDIM_W-1:0];
				cv2d_pkg::CFG_PAD_SAME:     pad_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective image size and kernel side.
	always_comb begin
		if (width_q == '0) begin
			w_eff = 7'd1;
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = cv2d_pkg::DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = 7'd1;
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = cv2d_pkg::DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
		k_clamp = (32'(ksize_q) > MAX_KERNEL) ? cv2d_pkg::KDIM_W'(MAX_KERNEL) : ksize_q;
		if (k_clamp == '0) begin
			k_eff = 3'd1;
		end else if (!k_clamp[0]) begin
			k_eff = k_clamp - 3'd1;
		end else begin
			k_eff = k_clamp;
		end
		off = pad_q ? cv2d_pkg::KDIM_W'((k_eff - 3'd1) >> 1) : '0;
	end

	// Output area check on the item being offered.
	always_comb begin
		if (pad_q) begin
			req_bad_c = (8'(in_item.row) >= 8'(h_eff)) || (8'(in_item.col) >= 8'(w_eff));
		end else begin
			req_bad_c = (8'(in_item.row) + 8'(k_eff) > 8'(h_eff))
				|| (8'(in_item.col) + 8'(k_eff) > 8'(w_eff));
		end
	end

	assign st.req_bad = req_bad_c;

	// Store writes at transfer of a weight or pixel item inside the store.
	assign pix_we = cmd.store && (in_item.mode == cv2d_pkg::MODE_PIXEL)
		&& (32'(in_item.row) < MAX_HEIGHT) && (32'(in_item.col) < MAX_WIDTH);
	assign wgt_we = cmd.store && (in_item.mode == cv2d_pkg::MODE_WEIGHT)
		&& (32'(in_item.row) < MAX_KERNEL) && (32'(in_item.col) < MAX_KERNEL);
	assign pix_wlin = 32'(in_item.row) * 32'(MAX_WIDTH) + 32'(in_item.col);
	assign wgt_wlin = 32'(in_item.row) * 32'(MAX_KERNEL) + 32'(in_item.col);

	// Window position of the current tap.
	assign r_c = $signed(cv2d_pkg::COORD_W'(row_q)) + $signed(cv2d_pkg::COORD_W'(i_q))
		- $signed(cv2d_pkg::COORD_W'(off));
	assign c_c = $signed(cv2d_pkg::COORD_W'(col_q)) + $signed(cv2d_pkg::COORD_W'(j_q))
		- $signed(cv2d_pkg::COORD_W'(off));
	assign in_image = !r_c[cv2d_pkg::COORD_W-1] && !c_c[cv2d_pkg::COORD_W-1]
		&& (r_c[MAG_W-1:0] < MAG_W'(h_eff)) && (c_c[MAG_W-1:0] < MAG_W'(w_eff));
	assign pix_rlin = 32'(r_c[MAG_W-1:0]) * 32'(MAX_WIDTH) + 32'(c_c[MAG_W-1:0]);
	assign wgt_rlin = 32'(i_q) * 32'(MAX_KERNEL) + 32'(j_q);

	cv2d_ram #(
		.WIDTH(cv2d_pkg::VALUE_W),
		.DEPTH(PIX_DEPTH)
	) u_pix_ram (
		.clk     (clk),
		.wr_en   (pix_we),
		.wr_addr (pix_wlin[PIX_AW-1:0]),
		.wr_data (in_item.value),
		.rd_addr (pix_rlin[PIX_AW-1:0]),
		.rd_data (pix_rdata)
	);

	cv2d_ram #(
		.WIDTH(cv2d_pkg::VALUE_W),
		.DEPTH(WGT_DEPTH)
	) u_wgt_ram (
		.clk     (clk),
		.wr_en   (wgt_we),
		.wr_addr (wgt_wlin[WGT_AW-1:0]),
		.wr_data (in_item.value),
		.rd_addr (wgt_rlin[WGT_AW-1:0]),
		.rd_data (wgt_rdata)
	);

	assign st.last_tap = (i_q == k_eff - 3'd1) && (j_q == k_eff - 3'd1);

	// Request capture and tap counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q   <= '0;
			j_q   <= '0;
			bad_q <= 1'b0;
		end else if (cmd.start) begin
			i_q   <= '0;
			j_q   <= '0;
			bad_q <= req_bad_c;
		end else if (cmd.tap) begin
			if (j_q == k_eff - 3'd1) begin
				j_q <= '0;
				i_q <= i_q + 3'd1;
			end else begin
				j_q <= j_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q <= in_item.row;
			col_q <= in_item.col;
		end
	end

	// Three-step multiply-accumulate: read, multiply, add.
	assign prod_c = $signed(pix_rdata) * $signed(wgt_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			tap_s1 <= cmd.tap;
			tap_s2 <= tap_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= !in_image;
		prod_s2 <= zero_s1 ? '0 : prod_c;
		if (cmd.start) begin
			acc_q <= '0;
		end else if (tap_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Saturate to the result width.
	always_comb begin
		acc_x = SAT_W'(acc_q);
		if (acc_x > SUM_TOP) begin
			sat_sum = SUM_TOP[cv2d_pkg::SUM_W-1:0];
		end else if (acc_x < SUM_BOT) begin
			sat_sum = SUM_BOT[cv2d_pkg::SUM_W-1:0];
		end else begin
			sat_sum = acc_x[cv2d_pkg::SUM_W-1:0];
		end
	end

	// Result register.
	assign st.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_item.sum          <= bad_q ? '0 : sat_sum;
			out_item.out_of_range <= bad_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/conv2d_valid_same_engine.sv =====
// Top level of the two-dimensional convolution engine.
// The input channel (in_valid, in_stall, in_item) carries three kinds of item:
// a kernel weight write, an image pixel write, or a request for the window sum
// at one output position. Weights and pixels outside their stores are dropped.
// A transfer happens at a rising edge with valid high and stall low.
// A write item leaves the controller idle, so it never holds the input.
// A compute request walks the k*k kernel taps, one multiply-accumulate per
// cycle through one pixel-RAM read port and one weight-RAM read port, then
// the drain states and a done state that waits for a free result register;
// only then is the next item taken. A request outside the output area goes
// straight to the done state: its result has sum zero and out_of_range set.
// The result channel (out_valid, out_stall, out_item) is one output register;
// items are still taken while a result waits, and only a second finished
// result holds the engine until the first is taken. The held result stays put.
// Reset sets the image to 10x10, the kernel to 3x3 and valid mode. The pixel
// and weight stores are not cleared, so every entry a window reads must have
// been written first. Configuration writes belong in idle periods only.
`default_nettype none

module conv2d_valid_same_engine #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_KERNEL = 5
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [cv2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [cv2d_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire cv2d_pkg::in_item_t              in_item,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output cv2d_pkg::out_item_t                  out_item
);

	cv2d_pkg::dp_cmd_t    cmd;
	cv2d_pkg::dp_status_t st;

	// The controller only sequences; all storage and arithmetic sit in the datapath.
	cv2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (in_item.mode),
		.st       (st),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	cv2d_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_KERNEL (MAX_KERNEL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ===== hdl/cv2d_chk.sv =====
// Port-level checker for the convolution engine and its bind statement.
`default_nettype none
`include "conv2d_valid_same_engine_defines.svh"

module cv2d_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire cv2d_pkg::in_item_t  in_item,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire cv2d_pkg::out_item_t out_item
);

	`CV2D_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
	`CV2D_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && out_item.out_of_range, out_item.sum == '0, "out-of-range result has a non-zero sum")
	`CV2D_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && !in_stall && (in_item.mode == cv2d_pkg::MODE_COMPUTE), in_stall, "compute request did not make the engine busy")
	`CV2D_ASSERT_NOW(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall), "result appeared without a busy cycle before it")

endmodule

bind conv2d_valid_same_engine cv2d_chk u_chk (.*);

`default_nettype wire

// ===== tb/conv2d_valid_same_engine_test.sv =====
// Self-checking testbench for the two-dimensional convolution engine.
module conv2d_valid_same_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	// The engine is built with its default store sizes, and the model below
	// mirrors them.
	localparam int IMG_MAX = 64;
	localparam int KER_MAX = 5;

	// Mode 3 has no meaning to the engine. It is sent only to show that it is
	// ignored.
	localparam logic [cv2d_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	// The slowest item is a 5x5 compute request. This pause is meant to be
	// longer than the time for which such a request keeps the input stalled.
	localparam int SETTLE_CYCLES = 40;
	localparam int ITEM_GOAL     = 1150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [cv2d_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [cv2d_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	cv2d_pkg::in_item_t  in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	cv2d_pkg::out_item_t out_item;

	// This is the testbench's own copy of the engine state. The flags record
	// which store entries have been written. A compute request never reads
	// an entry that has not been written.
	logic signed [cv2d_pkg::VALUE_W-1:0] pixel_mem [IMG_MAX][IMG_MAX];
	logic signed [cv2d_pkg::VALUE_W-1:0] coef_mem [KER_MAX][KER_MAX];
	bit   pixel_known [IMG_MAX][IMG_MAX];
	bit   coef_known [KER_MAX][KER_MAX];
	int   cfg_width  = 10;
	int   cfg_height = 10;
	int   cfg_kernel = 3;
	bit   cfg_same   = 1'b0;

	// These are the window sums still owed by the engine, oldest first.
	cv2d_pkg::out_item_t pending_sums[$];

	int mismatch_count = 0;
	int work_items = 0;
	int idle_pct = 22;
	int stall_pct = 22;
	int hold_request = 0;
	int hold_left = 0;

	conv2d_valid_same_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	always #10 clk = ~clk;

	// These functions give the dimensions that the engine actually uses once
	// it has clamped the raw register values.
	function automatic int eff_width();
		return (cfg_width < 1) ? 1 : (cfg_width > IMG_MAX) ? IMG_MAX : cfg_width;
	endfunction

	function automatic int eff_height();
		return (cfg_height < 1) ? 1 : (cfg_height > IMG_MAX) ? IMG_MAX : cfg_height;
	endfunction

	// A kernel size above the maximum is clamped. An even size drops to the
	// odd size below it, and a size of zero counts as one.
	function automatic int eff_kernel();
		int k;
		k = (cfg_kernel > KER_MAX) ? KER_MAX : cfg_kernel;
		if (k % 2 == 0) begin
			k = (k == 0) ? 1 : k - 1;
		end
		return k;
	endfunction

	// In valid mode the whole window must fit inside the image. In same mode
	// any pixel of the image is a legal centre.
	function automatic bit position_outside(input int row, input int col);
		if (cfg_same) begin
			return row >= eff_height() || col >= eff_width();
		end
		return row + eff_kernel() > eff_height() || col + eff_kernel() > eff_width();
	endfunction

	// This function predicts the result of one compute request. In same mode
	// taps that fall outside the image read as zero.
	function automatic cv2d_pkg::out_item_t window_sum(input int row, input int col);
		cv2d_pkg::out_item_t res;
		longint acc;
		int k, off, r, c;
		res.sum = '0;
		res.out_of_range = 1'b1;
		if (position_outside(row, col)) begin
			return res;
		end
		k = eff_kernel();
		off = cfg_same ? (k - 1) / 2 : 0;
		acc = 0;
		for (int i = 0; i < k; i++) begin
			for (int j = 0; j < k; j++) begin
				r = row + i - off;
				c = col + j - off;
				if (r >= 0 && c >= 0 && r < eff_height() && c < eff_width()) begin
					acc += longint'(pixel_mem[r][c]) * longint'(coef_mem[i][j]);
				end
			end
		end
		// The sum saturates to the width of the result field.
		if (acc > (64'sd1 <<< (cv2d_pkg::SUM_W - 1)) - 1) begin
			acc = (64'sd1 <<< (cv2d_pkg::SUM_W - 1)) - 1;
		end
		if (acc < -(64'sd1 <<< (cv2d_pkg::SUM_W - 1))) begin
			acc = -(64'sd1 <<< (cv2d_pkg::SUM_W - 1));
		end
		res.sum = acc[cv2d_pkg::SUM_W-1:0];
		res.out_of_range = 1'b0;
		return res;
	endfunction

	// This function picks a random sample. About one time in seven it picks
	// the largest or smallest signed 16-bit integer, or zero, instead.
	function automatic logic [cv2d_pkg::VALUE_W-1:0] random_sample();
		case ($urandom_range(19))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return cv2d_pkg::VALUE_W'($urandom);
		endcase
	endfunction

	// This function returns a coordinate below n. It leans towards the two
	// borders, where the padding and the edges of the area need testing.
	function automatic int pick_coord(input int n);
		if (n <= 1) begin
			return 0;
		end
		case ($urandom_range(3))
			0: return 0;
			1: return n - 1;
			default: return $urandom_range(n - 1);
		endcase
	endfunction

	// This task offers one item to the engine and holds it steady until the
	// transfer. It sometimes idles first. It returns just after the rising
	// edge of the transfer, and at that edge it updates the model.
	task automatic send_item(input cv2d_pkg::in_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= item;
		do @(posedge clk); while (in_stall);
		case (item.mode)
			cv2d_pkg::MODE_WEIGHT: begin
				if (item.row < KER_MAX && item.col < KER_MAX) begin
					coef_mem[item.row][item.col] = item.value;
					coef_known[item.row][item.col] = 1'b1;
					work_items++;
				end
			end
			cv2d_pkg::MODE_PIXEL: begin
				pixel_mem[item.row][item.col] = item.value;
				pixel_known[item.row][item.col] = 1'b1;
				work_items++;
			end
			cv2d_pkg::MODE_COMPUTE: begin
				pending_sums.push_back(window_sum(item.row, item.col));
				work_items++;
			end
			default: ;
		endcase
	endtask

	task automatic send_fields(input logic [cv2d_pkg::MODE_W-1:0] mode, input int row,
			input int col, input logic [cv2d_pkg::VALUE_W-1:0] value);
		cv2d_pkg::in_item_t item;
		item.mode = mode;
		item.row = row[cv2d_pkg::ROW_W-1:0];
		item.col = col[cv2d_pkg::ROW_W-1:0];
		item.value = value;
		send_item(item);
	endtask

	// This task drops the input valid and waits until every result that is
	// owed has been taken. If settle is set, it then also waits out the
	// SETTLE_CYCLES pause.
	task automatic wait_results_drained(input bit settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0) begin
			@(negedge clk);
		end
		if (settle) begin
			repeat (SETTLE_CYCLES) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [cv2d_pkg::CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= cv2d_pkg::CFG_DATA_W'(value);
		case (idx)
			cv2d_pkg::CFG_IMAGE_WIDTH:  cfg_width = value & 'h7F;
			cv2d_pkg::CFG_IMAGE_HEIGHT: cfg_height = value & 'h7F;
			cv2d_pkg::CFG_KERNEL_SIZE:  cfg_kernel = value & 'h7;
			cv2d_pkg::CFG_PAD_SAME:     cfg_same = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// This task writes all four registers. The engine is left to go idle
	// first.
	task automatic write_config(input int w, input int h, input int k, input int pad);
		wait_results_drained(1'b1);
		write_reg(cv2d_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(cv2d_pkg::CFG_IMAGE_HEIGHT, h);
		write_reg(cv2d_pkg::CFG_KERNEL_SIZE, k);
		write_reg(cv2d_pkg::CFG_PAD_SAME, pad);
	endtask

	// This task writes any weight or pixel that a legal request at (row, col)
	// would read and that has not been written yet. The stores power up with
	// undefined contents, so this step must come first.
	task automatic prepare_window(input int row, input int col);
		int k, off, r, c;
		if (position_outside(row, col)) begin
			return;
		end
		k = eff_kernel();
		off = cfg_same ? (k - 1) / 2 : 0;
		for (int i = 0; i < k; i++) begin
			for (int j = 0; j < k; j++) begin
				if (!coef_known[i][j]) begin
					send_fields(cv2d_pkg::MODE_WEIGHT, i, j, random_sample());
				end
				r = row + i - off;
				c = col + j - off;
				if (r >= 0 && c >= 0 && r < eff_height() && c < eff_width()
						&& !pixel_known[r][c]) begin
					send_fields(cv2d_pkg::MODE_PIXEL, r, c, random_sample());
				end
			end
		end
	endtask

	// This task sends one compute request. Most requests fall inside the
	// output area. Some fall anywhere in the 6-bit range and so test the
	// out-of-range flag.
	task automatic random_compute();
		int row, col, k;
		k = eff_kernel();
		if ($urandom_range(99) < 15) begin
			row = $urandom_range(63);
			col = $urandom_range(63);
		end else if (cfg_same) begin
			row = pick_coord(eff_height());
			col = pick_coord(eff_width());
		end else if (eff_height() >= k && eff_width() >= k) begin
			row = pick_coord(eff_height() - k + 1);
			col = pick_coord(eff_width() - k + 1);
		end else begin
			row = $urandom_range(63);
			col = $urandom_range(63);
		end
		prepare_window(row, col);
		send_fields(cv2d_pkg::MODE_COMPUTE, row, col, cv2d_pkg::VALUE_W'($urandom));
	endtask

	// This task sends one random item. Most items are compute requests or
	// pixel and weight writes that fall inside the current setting. The
	// rest are writes outside the image or the kernel, dropped weights, and
	// the unused mode.
	task automatic random_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50) begin
			random_compute();
		end else if (pick < 78) begin
			if ($urandom_range(9) == 0) begin
				send_fields(cv2d_pkg::MODE_PIXEL, $urandom_range(63), $urandom_range(63),
					random_sample());
			end else begin
				send_fields(cv2d_pkg::MODE_PIXEL, pick_coord(eff_height()),
					pick_coord(eff_width()), random_sample());
			end
		end else if (pick < 92) begin
			if ($urandom_range(9) < 8) begin
				send_fields(cv2d_pkg::MODE_WEIGHT, pick_coord(eff_kernel()),
					pick_coord(eff_kernel()), random_sample());
			end else begin
				send_fields(cv2d_pkg::MODE_WEIGHT, $urandom_range(KER_MAX - 1),
					$urandom_range(KER_MAX - 1), random_sample());
			end
		end else if (pick < 96) begin
			send_fields(cv2d_pkg::MODE_WEIGHT, $urandom_range(KER_MAX, 63),
				$urandom_range(63), random_sample());
		end else begin
			send_fields(MODE_UNUSED, $urandom_range(63), $urandom_range(63),
				cv2d_pkg::VALUE_W'($urandom));
		end
	endtask

	// This test runs with the reset setting (10x10 image, 3x3 kernel, valid
	// mode). A window of most-negative samples gives the largest positive
	// sum. A most-positive weight and pixel then show the sign handling. Then
	// come the unused mode, weights outside the kernel store, a pixel at the
	// far corner of the store, and requests past the output area.
	task automatic test_reset_setting();
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				send_fields(cv2d_pkg::MODE_WEIGHT, i, j, 16'h8000);
				send_fields(cv2d_pkg::MODE_PIXEL, i, j, 16'h8000);
			end
		end
		send_fields(cv2d_pkg::MODE_COMPUTE, 0, 0, 16'h0000);
		send_fields(cv2d_pkg::MODE_WEIGHT, 1, 1, 16'h7FFF);
		send_fields(cv2d_pkg::MODE_PIXEL, 2, 2, 16'h7FFF);
		send_fields(cv2d_pkg::MODE_COMPUTE, 0, 0, 16'hFFFF);
		send_fields(MODE_UNUSED, 63, 63, 16'hFFFF);
		send_fields(cv2d_pkg::MODE_WEIGHT, KER_MAX, 0, 16'h1234);
		send_fields(cv2d_pkg::MODE_WEIGHT, 63, 63, 16'hFFFF);
		send_fields(cv2d_pkg::MODE_PIXEL, 63, 63, 16'h5A5A);
		send_fields(cv2d_pkg::MODE_COMPUTE, 8, 0, 16'h0000);
		send_fields(cv2d_pkg::MODE_COMPUTE, 0, 8, 16'h0000);
		send_fields(cv2d_pkg::MODE_COMPUTE, 63, 63, 16'hFFFF);
	endtask

	// This test tries every raw kernel size, 0 to 7, in both modes. It also
	// uses one setting in which the kernel is larger than the image, so the
	// output area is empty.
	task automatic test_kernel_sizes();
		for (int kc = 0; kc < 8; kc++) begin
			for (int pad = 0; pad < 2; pad++) begin
				write_config($urandom_range(3, 9), $urandom_range(3, 9), kc, pad);
				repeat (6) random_compute();
			end
		end
		write_config(4, 3, 5, 0);
		repeat (4) random_compute();
	endtask

	// This test uses image sizes at the ends of the register range: zero,
	// which is clamped up to one, one, the full 64, and 127, which is
	// clamped down to 64.
	task automatic test_image_extremes();
		int ext_w[6] = '{0, 1, 127, 64, 1, 64};
		int ext_h[6] = '{0, 1, 127, 64, 64, 1};
		int ext_k[3] = '{1, 3, 5};
		for (int s = 0; s < 6; s++) begin
			for (int pad = 0; pad < 2; pad++) begin
				write_config(ext_w[s], ext_h[s], ext_k[$urandom_range(2)], pad);
				repeat (6) random_compute();
			end
		end
	endtask

	// This test fills an 8x8 image and then runs with no idling on either
	// side. The result side then holds off for a long time while compute
	// requests keep coming. The engine fills up and stalls its input, and it
	// has to resume cleanly once the hold ends.
	task automatic test_back_pressure();
		write_config(8, 8, 5, 1);
		idle_pct = 0;
		stall_pct = 0;
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				send_fields(cv2d_pkg::MODE_PIXEL, r, c, random_sample());
			end
		end
		for (int i = 0; i < KER_MAX; i++) begin
			for (int j = 0; j < KER_MAX; j++) begin
				send_fields(cv2d_pkg::MODE_WEIGHT, i, j, random_sample());
			end
		end
		repeat (40) random_compute();
		hold_request = 400;
		repeat (30) random_compute();
		idle_pct = 22;
		stall_pct = 22;
	endtask

	// In this test the sender stops in the middle of a stream and waits
	// until every result has come back. It then carries on without touching
	// the configuration.
	task automatic test_sender_pause();
		write_config(6, 7, 3, 1);
		repeat (15) random_step();
		wait_results_drained(1'b0);
		repeat (15) random_step();
	endtask

	// This test draws a random setting for each phase and then sends a
	// random stream. Most images are small. Now and then a phase uses an
	// extreme size.
	task automatic test_random_traffic();
		int dims[2];
		while (work_items < ITEM_GOAL) begin
			foreach (dims[d]) begin
				case ($urandom_range(19))
					0: dims[d] = 0;
					1: dims[d] = 127;
					2: dims[d] = 1;
					3: dims[d] = 64;
					default: dims[d] = $urandom_range(2, 12);
				endcase
			end
			write_config(dims[0], dims[1], $urandom_range(7), $urandom_range(1));
			repeat ($urandom_range(30, 80)) random_step();
		end
	endtask

	// The result side stalls at random, except when a test asks for a long
	// hold. That hold is counted down here, one cycle at a time.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin : check_results
		cv2d_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				$error("out_item: result transfer with no compute request pending");
				mismatch_count++;
			end else begin
				want = pending_sums.pop_front();
				if (out_item.sum !== want.sum) begin
					$error("sum: expected %0d, got %0d", want.sum, out_item.sum);
					mismatch_count++;
				end
				if (out_item.out_of_range !== want.out_of_range) begin
					$error("out_of_range: expected %0b, got %0b", want.out_of_range,
						out_item.out_of_range);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_setting();
		test_kernel_sizes();
		test_image_extremes();
		test_back_pressure();
		test_sender_pause();
		test_random_traffic();
		wait_results_drained(1'b1);
		if (mismatch_count == 0) begin
			$display("PASS conv2d_valid_same_engine");
		end else begin
			$display("FAIL conv2d_valid_same_engine");
		end
		$finish;
	end

	// A correct run takes a few milliseconds of simulated time. This limit
	// is several times that.
	initial begin
		#20ms;
		$display("FAIL conv2d_valid_same_engine");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cv2d_pkg.sv
hdl/cv2d_ram.sv
hdl/cv2d_ctrl.sv
hdl/cv2d_dp.sv
hdl/conv2d_valid_same_engine.sv
hdl/cv2d_chk.sv
tb/conv2d_valid_same_engine_test.sv
